FILE: design/rgbwpb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbwpb_pkg
// Types, constants and the table builders of the perceptual RGBW blend.
// ----------------------------------------------------------------------------
package rgbwpb_pkg;

    localparam int unsigned CH_W      = 8;
    localparam int unsigned ROM_DEPTH = 256;
    localparam longint unsigned CIE_DEN = 64'd63435789;
    localparam longint unsigned CIE_DEN2 = 64'd2 * CIE_DEN;
    localparam int unsigned LIN_DEN   = 18066;

    // reciprocal of 255 in 2^23 fixed point, exact for 16-bit magnitudes
    localparam int unsigned RECIP_W     = 17;
    localparam logic [RECIP_W-1:0] RECIP_255 = 17'd32897;
    localparam int unsigned RECIP_SHIFT = 23;

    typedef logic [CH_W-1:0] chan_t;
    typedef chan_t rom_t [ROM_DEPTH];

    function automatic rom_t build_pwm();
        rom_t             rom;
        longint unsigned  s;
        longint unsigned  n;
        for (int p = 0; p < ROM_DEPTH; p++) begin
            if (p <= 20) begin
                rom[p] = chan_t'((2000 * p + 9033) / LIN_DEN);
            end else begin
                s = 64'(5 * p + 204);
                n = 64'd10 * s * s * s;
                rom[p] = chan_t'((n + CIE_DEN) / CIE_DEN2);
            end
        end
        return rom;
    endfunction

    function automatic rom_t build_light();
        rom_t rom;
        rom_t pwm;
        int   p;
        pwm = build_pwm();
        p   = 0;
        for (int x = 0; x < ROM_DEPTH; x++) begin
            while (p < ROM_DEPTH - 1 && int'(pwm[p]) < x) begin
                p++;
            end
            rom[x] = chan_t'(p);
        end
        return rom;
    endfunction

endpackage

FILE: design/rgbw_perceptual_blend.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbw_perceptual_blend
// Blends two RGBW colors channel by channel in CIE lightness space.
// ----------------------------------------------------------------------------
// One request per clock through four register stages. Each lane reads
// the lightness ROM, multiplies the lightness difference by the weight,
// divides by 255 through a reciprocal multiply, then reads the CIE 1931 PWM
// ROM into the output register. A weight of 0 returns the start color, 255
// the end color. Back-pressure on m_tready stalls the pipe; bubbles are
// squeezed out.
// ----------------------------------------------------------------------------
module rgbw_perceptual_blend #(
    parameter int CHANNELS = 4
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // from_* channels, to_* channels, weight (lowest bits first)
    input  logic [(2*CHANNELS+1)*8-1:0]   s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // out_* channels (lowest bits first)
    output logic [CHANNELS*8-1:0]         m_tdata
);

    localparam int W = rgbwpb_pkg::CH_W;
    localparam rgbwpb_pkg::rom_t LIGHT_ROM = rgbwpb_pkg::build_light();
    localparam rgbwpb_pkg::rom_t PWM_ROM   = rgbwpb_pkg::build_pwm();

    logic [3:0] vld_reg;
    logic [3:0] vld_next;
    logic [3:0] en;

    logic [CHANNELS-1:0][W-1:0] a_in, b_in;
    logic [W-1:0]               t_in;

    logic [2:0]                        zero_reg, full_reg;
    logic [W-1:0]                      t1_reg;
    logic [2:0][CHANNELS-1:0][W-1:0]   a_reg, b_reg;
    logic [2:0][CHANNELS-1:0][W-1:0]   la_reg;
    logic [CHANNELS-1:0][W-1:0]        lb_reg;
    logic [CHANNELS-1:0][2*W-1:0]      mag_reg;
    logic [1:0][CHANNELS-1:0]          neg_reg;
    logic [CHANNELS-1:0][W-1:0]        q_reg;
    logic [CHANNELS-1:0][W-1:0]        out_reg;

    assign t_in = s_tdata[2*CHANNELS*W +: W];

    always_comb begin
        en[3] = !vld_reg[3] || m_tready;
        for (int k = 2; k >= 0; k--) begin
            en[k] = !vld_reg[k] || en[k+1];
        end
        vld_next = vld_reg;
        if (en[0]) vld_next[0] = s_tvalid;
        for (int k = 1; k < 4; k++) begin
            if (en[k]) vld_next[k] = vld_reg[k-1];
        end
    end

    assign s_tready = en[0];
    assign m_tvalid = vld_reg[3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    // advance side-band data
    always_ff @(posedge aclk) begin
        if (en[0]) begin
            zero_reg[0] <= (t_in == '0);
            full_reg[0] <= (t_in == '1);
            t1_reg      <= t_in;
            a_reg[0]    <= a_in;
            b_reg[0]    <= b_in;
        end
        if (en[1]) begin
            zero_reg[1] <= zero_reg[0];
            full_reg[1] <= full_reg[0];
            a_reg[1]    <= a_reg[0];
            b_reg[1]    <= b_reg[0];
        end
        if (en[2]) begin
            zero_reg[2] <= zero_reg[1];
            full_reg[2] <= full_reg[1];
            a_reg[2]    <= a_reg[1];
            b_reg[2]    <= b_reg[1];
        end
    end

    for (genvar i = 0; i < CHANNELS; i++) begin : g_lane
        logic signed [W:0]     diff;
        logic signed [2*W:0]   prod;
        logic [2*W-1:0]        mag;
        logic [2*W+rgbwpb_pkg::RECIP_W-1:0] recip;
        logic [W-1:0]          blend;

        assign a_in[i] = s_tdata[i*W +: W];
        assign b_in[i] = s_tdata[(CHANNELS+i)*W +: W];

        assign diff  = $signed({1'b0, lb_reg[i]}) - $signed({1'b0, la_reg[0][i]});
        assign prod  = diff * $signed({1'b0, t1_reg});
        assign mag   = prod[2*W] ? (2*W)'(-prod) : prod[2*W-1:0];
        assign recip = mag_reg[i] * rgbwpb_pkg::RECIP_255;
        assign blend = neg_reg[1][i] ? (la_reg[2][i] - q_reg[i])
                                     : (la_reg[2][i] + q_reg[i]);

        // stage 1: lightness ROM read
        always_ff @(posedge aclk) begin
            if (en[0]) begin
                la_reg[0][i] <= LIGHT_ROM[a_in[i]];
                lb_reg[i]    <= LIGHT_ROM[b_in[i]];
            end
        end

        // stage 2: weighted difference
        always_ff @(posedge aclk) begin
            if (en[1]) begin
                mag_reg[i]    <= mag;
                neg_reg[0][i] <= prod[2*W];
                la_reg[1][i]  <= la_reg[0][i];
            end
        end

        // stage 3: divide by 255
        always_ff @(posedge aclk) begin
            if (en[2]) begin
                q_reg[i]      <= recip[rgbwpb_pkg::RECIP_SHIFT +: W];
                neg_reg[1][i] <= neg_reg[0][i];
                la_reg[2][i]  <= la_reg[1][i];
            end
        end

        // stage 4: PWM ROM read into the output register, or the start or end color for a weight of 0 or 255
        always_ff @(posedge aclk) begin
            if (en[3]) begin
                if (zero_reg[2]) begin
                    out_reg[i] <= a_reg[2][i];
                end else if (full_reg[2]) begin
                    out_reg[i] <= b_reg[2][i];
                end else begin
                    out_reg[i] <= PWM_ROM[blend];
                end
            end
        end

        assign m_tdata[i*W +: W] = out_reg[i];
    end

endmodule
